### rtl/dfg_pkg.sv
// ----------------------------------------------------------------------------
// dfg_pkg
// Shared types and constants of the DVFS frequency governor.
// ----------------------------------------------------------------------------
package dfg_pkg;

	localparam int FREQ_W     = 22;
	localparam int THR_W      = 32;
	localparam int SLEEP_W    = 24;
	localparam int FCNT_W     = 5;
	localparam int PROD1_W    = FREQ_W + THR_W;     // cur * req
	localparam int PSLEEP_W   = SLEEP_W + THR_W;    // sleep * thr
	localparam int DVS_W      = 36;                 // divisor width
	localparam int DVD_W      = FREQ_W + DVS_W;     // dividend width
	localparam int CNT_W      = $clog2(DVD_W);

	// one million in q16.16
	localparam logic [DVS_W-1:0] S_MEGA = 36'd65536000000;

	// S_MEGA is MEGA_ODD shifted up by SCALE_SH
	localparam int SCALE_SH = 22;
	localparam int ODD_W    = 14;
	localparam logic [ODD_W-1:0] MEGA_ODD = 14'd15625;

	// floor(2^36 / MEGA_ODD), estimate is low by at most one
	localparam int RCP_W  = 23;
	localparam logic [RCP_W-1:0] RCP_M = 23'd4398046;
	localparam int PRCP_W = DVS_W + RCP_W;

	localparam int MAX_APPS_DEF     = 8;
	localparam int FREQ_ENTRIES_DEF = 16;

	localparam logic [FREQ_W-1:0] MIN_RST = 22'd102000;
	localparam logic [FREQ_W-1:0] MAX_RST = 22'd1479000;
	localparam logic [FCNT_W-1:0] FCNT_RST = 5'd1;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_REPORT = 2'd1,
		MODE_END    = 2'd2,
		MODE_TABLE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_MIN   = 2'd0,
		CFG_MAX   = 2'd1,
		CFG_COUNT = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		WSEL_MAX  = 2'd0,
		WSEL_ZERO = 2'd1,
		WSEL_DIV  = 2'd2,
		WSEL_HOLD = 2'd3
	} wsel_t;

	// controller to datapath
	typedef struct packed {
		logic  accept;
		logic  mult1;
		logic  div_go;
		logic  t_load;
		logic  mult2;
		logic  rcp;
		logic  qest;
		logic  w_load;
		wsel_t w_sel;
		logic  srch_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic thr_zero;
		logic p_over;
		logic div_done;
		logic srch_hit;
	} sts_t;

endpackage

### rtl/dfg_div.sv
// ----------------------------------------------------------------------------
// dfg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dfg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [dfg_pkg::DVD_W-1:0]    dividend,
	input  logic [dfg_pkg::DVS_W-1:0]    divisor,
	output logic [dfg_pkg::DVD_W-1:0]    quotient,
	output logic                         done
);

	logic [dfg_pkg::DVS_W-1:0] rem_q;
	logic [dfg_pkg::DVD_W-1:0] quo_q;
	logic [dfg_pkg::DVS_W-1:0] dvs_q;
	logic [dfg_pkg::CNT_W-1:0] cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [dfg_pkg::DVS_W:0]   trial;
	logic                      fits;

	// trial subtraction
	assign trial = {rem_q, quo_q[dfg_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dfg_pkg::CNT_W'(dfg_pkg::DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= dfg_pkg::DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[dfg_pkg::DVS_W-1:0];
			end
			quo_q <= {quo_q[dfg_pkg::DVD_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### rtl/dfg_dp.sv
// ----------------------------------------------------------------------------
// dfg_dp
// Datapath: settings, application table, frequency table, report arithmetic,
// table search and epoch result.
// ----------------------------------------------------------------------------
module dfg_dp #(
	parameter int MAX_APPS     = dfg_pkg::MAX_APPS_DEF,
	parameter int FREQ_ENTRIES = dfg_pkg::FREQ_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfg_pkg::cmd_t                 cmd,
	output dfg_pkg::sts_t                 sts,
	input  logic [1:0]                    mode,
	input  logic [dfg_pkg::FREQ_W-1:0]    current_freq_khz,
	input  logic [dfg_pkg::FREQ_W-1:0]    app_id,
	input  logic [dfg_pkg::THR_W-1:0]     throughput,
	input  logic [dfg_pkg::THR_W-1:0]     required_throughput,
	input  logic [dfg_pkg::SLEEP_W-1:0]   sleep_us,
	input  logic [3:0]                    table_index,
	input  logic [dfg_pkg::FREQ_W-1:0]    table_value_khz,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [dfg_pkg::FREQ_W-1:0]    cfg_data,
	output logic                          done,
	output logic [dfg_pkg::FREQ_W-1:0]    target_freq_khz,
	output logic                          apply_change,
	output logic                          new_app_seen,
	output logic                          ended_app_seen,
	output logic                          table_full_error
);

	localparam int IW = (FREQ_ENTRIES > 1) ? $clog2(FREQ_ENTRIES) : 1;

	// settings
	logic [dfg_pkg::FREQ_W-1:0]  min_q, max_q;
	logic [dfg_pkg::FCNT_W-1:0]  fcnt_q;

	// epoch state
	logic [MAX_APPS-1:0]          valid_q, seen_q;
	logic [dfg_pkg::FREQ_W-1:0]   pid_q [MAX_APPS];
	logic [dfg_pkg::FREQ_W-1:0]   freq_q [FREQ_ENTRIES];
	logic [dfg_pkg::FREQ_W-1:0]   cur_q, best_q;
	logic                         new_q, full_q;

	// report arithmetic
	logic [dfg_pkg::THR_W-1:0]    thr_q, req_q;
	logic [dfg_pkg::SLEEP_W-1:0]  sleep_q;
	logic [dfg_pkg::PROD1_W-1:0]  prod1_q;
	logic [dfg_pkg::PSLEEP_W-1:0] psl_q;
	logic [dfg_pkg::DVS_W-1:0]    sp_q;
	logic                         pov_q;
	logic [dfg_pkg::FREQ_W-1:0]   t_q, w_q;
	logic [dfg_pkg::DVD_W-1:0]    prod2_q;
	logic [dfg_pkg::DVS_W-1:0]    scaled;
	logic [dfg_pkg::PRCP_W-1:0]   rcp_q;
	logic [dfg_pkg::FREQ_W-1:0]   qe_q;
	logic [dfg_pkg::DVS_W-1:0]    rm_q;
	logic [IW-1:0]                k_q;

	// output registers
	logic                         done_q, apply_q, newo_q, endo_q, fullo_q;
	logic [dfg_pkg::FREQ_W-1:0]   tgt_q;

	// divider
	logic [dfg_pkg::DVD_W-1:0]    dvd, quo;
	logic [dfg_pkg::DVS_W-1:0]    dvs;
	logic                         dv_done;

	assign dvd = dfg_pkg::DVD_W'(prod1_q);
	assign dvs = dfg_pkg::DVS_W'(thr_q);

	dfg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (dv_done)
	);

	// product with the low zero bits of S_MEGA divided out
	assign scaled = prod2_q[dfg_pkg::DVD_W-1:dfg_pkg::SCALE_SH];

	// application lookup and free slot
	logic [MAX_APPS-1:0] hit;
	logic [MAX_APPS-1:0] free_one;
	logic                free_any;
	always_comb begin
		free_one = '0;
		free_any = 1'b0;
		for (int i = 0; i < MAX_APPS; i++) begin
			hit[i] = valid_q[i] && (pid_q[i] == app_id);
			if (!valid_q[i] && !free_any) begin
				free_one[i] = 1'b1;
				free_any    = 1'b1;
			end
		end
	end

	// table search bounds and current entry
	logic [6:0]                 nn;
	logic [IW-1:0]              last_k;
	logic [dfg_pkg::FREQ_W-1:0] entry;
	always_comb begin
		if (fcnt_q == '0) begin
			nn = 7'd1;
		end else if (7'(fcnt_q) > 7'(FREQ_ENTRIES)) begin
			nn = 7'(FREQ_ENTRIES);
		end else begin
			nn = 7'(fcnt_q);
		end
		last_k = IW'(nn - 7'd1);
		entry  = freq_q[k_q];
	end

	// epoch end clamp
	logic [dfg_pkg::FREQ_W-1:0] clamp;
	always_comb begin
		if (best_q > max_q) begin
			clamp = max_q;
		end else if (best_q < min_q) begin
			clamp = min_q;
		end else begin
			clamp = best_q;
		end
	end

	assign sts.thr_zero = (thr_q == '0);
	assign sts.p_over   = pov_q;
	assign sts.div_done = dv_done;
	assign sts.srch_hit = (entry >= w_q) || (k_q == last_k);

	// settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= dfg_pkg::MIN_RST;
			max_q  <= dfg_pkg::MAX_RST;
			fcnt_q <= dfg_pkg::FCNT_RST;
		end else if (cfg_we) begin
			case (dfg_pkg::cfg_idx_t'(cfg_index))
				dfg_pkg::CFG_MIN:   min_q  <= cfg_data;
				dfg_pkg::CFG_MAX:   max_q  <= cfg_data;
				dfg_pkg::CFG_COUNT: fcnt_q <= cfg_data[dfg_pkg::FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// epoch state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seen_q  <= '0;
			cur_q   <= '0;
			best_q  <= '0;
			new_q   <= 1'b0;
			full_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.accept) begin
				case (dfg_pkg::mode_t'(mode))
					dfg_pkg::MODE_START: begin
						cur_q  <= current_freq_khz;
						seen_q <= '0;
						best_q <= min_q;
						new_q  <= 1'b0;
						full_q <= 1'b0;
					end
					dfg_pkg::MODE_REPORT: begin
						if (|hit) begin
							seen_q <= seen_q | hit;
						end else if (free_any) begin
							valid_q <= valid_q | free_one;
							seen_q  <= seen_q | free_one;
							new_q   <= 1'b1;
						end else begin
							full_q <= 1'b1;
						end
					end
					dfg_pkg::MODE_END: begin
						valid_q <= valid_q & seen_q;
						done_q  <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.srch_step && sts.srch_hit && (entry > best_q)) begin
				best_q <= entry;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			case (dfg_pkg::mode_t'(mode))
				dfg_pkg::MODE_REPORT: begin
					thr_q   <= throughput;
					req_q   <= required_throughput;
					sleep_q <= sleep_us;
					if (!(|hit) && free_any) begin
						for (int i = 0; i < MAX_APPS; i++) begin
							if (free_one[i]) pid_q[i] <= app_id;
						end
					end
				end
				dfg_pkg::MODE_TABLE: begin
					for (int e = 0; e < FREQ_ENTRIES; e++) begin
						if ({28'd0, table_index} == 32'(e)) freq_q[e] <= table_value_khz;
					end
				end
				dfg_pkg::MODE_END: begin
					tgt_q   <= clamp;
					apply_q <= !new_q && (clamp != cur_q);
					newo_q  <= new_q;
					endo_q  <= |(valid_q & ~seen_q);
					fullo_q <= full_q;
				end
				default: ;
			endcase
		end
		// products
		if (cmd.mult1) begin
			prod1_q <= dfg_pkg::PROD1_W'(cur_q) * dfg_pkg::PROD1_W'(req_q);
			psl_q   <= dfg_pkg::PSLEEP_W'(sleep_q) * dfg_pkg::PSLEEP_W'(thr_q);
		end
		// sleep factor, settles while dividing
		pov_q <= psl_q >= dfg_pkg::PSLEEP_W'(dfg_pkg::S_MEGA);
		sp_q  <= dfg_pkg::S_MEGA - psl_q[dfg_pkg::DVS_W-1:0];
		// saturated first quotient
		if (cmd.t_load) begin
			t_q <= (|quo[dfg_pkg::DVD_W-1:dfg_pkg::FREQ_W]) ? '1
				: quo[dfg_pkg::FREQ_W-1:0];
		end
		if (cmd.mult2) begin
			prod2_q <= dfg_pkg::DVD_W'(t_q) * dfg_pkg::DVD_W'(sp_q);
		end
		// division by the odd part of S_MEGA: reciprocal estimate
		if (cmd.rcp) begin
			rcp_q <= dfg_pkg::PRCP_W'(scaled) * dfg_pkg::PRCP_W'(dfg_pkg::RCP_M);
		end
		// estimate and its remainder
		if (cmd.qest) begin
			qe_q <= rcp_q[dfg_pkg::DVS_W +: dfg_pkg::FREQ_W];
			rm_q <= scaled - dfg_pkg::DVS_W'(rcp_q[dfg_pkg::DVS_W +: dfg_pkg::FREQ_W])
				* dfg_pkg::DVS_W'(dfg_pkg::MEGA_ODD);
		end
		// wanted frequency and search start
		if (cmd.w_load) begin
			k_q <= '0;
			case (cmd.w_sel)
				dfg_pkg::WSEL_MAX:  w_q <= max_q;
				dfg_pkg::WSEL_ZERO: w_q <= '0;
				dfg_pkg::WSEL_DIV:  w_q <= qe_q
					+ dfg_pkg::FREQ_W'(rm_q >= dfg_pkg::DVS_W'(dfg_pkg::MEGA_ODD));
				default: ;
			endcase
		end else if (cmd.srch_step && !sts.srch_hit) begin
			k_q <= k_q + 1'b1;
		end
	end

	assign done             = done_q;
	assign target_freq_khz  = tgt_q;
	assign apply_change     = apply_q;
	assign new_app_seen     = newo_q;
	assign ended_app_seen   = endo_q;
	assign table_full_error = fullo_q;

endmodule

### rtl/dfg_ctrl.sv
// ----------------------------------------------------------------------------
// dfg_ctrl
// Sequencer for report arithmetic; other modes finish in the accept cycle.
// ----------------------------------------------------------------------------
module dfg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    mode,
	input  dfg_pkg::sts_t sts,
	output dfg_pkg::cmd_t cmd,
	output logic          busy
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_CHK, ST_DIV1, ST_MUL2, ST_RCP, ST_QEST, ST_FIX, ST_SRCH
	} state_t;

	state_t state_q;

	assign busy = (state_q != ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start && dfg_pkg::mode_t'(mode) == dfg_pkg::MODE_REPORT) begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_CHK;
				ST_CHK:  state_q <= sts.thr_zero ? ST_SRCH : ST_DIV1;
				ST_DIV1: if (sts.div_done) begin
					state_q <= sts.p_over ? ST_SRCH : ST_MUL2;
				end
				ST_MUL2: state_q <= ST_RCP;
				ST_RCP:  state_q <= ST_QEST;
				ST_QEST: state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_SRCH;
				ST_SRCH: if (sts.srch_hit) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.w_sel     = dfg_pkg::WSEL_HOLD;
		cmd.accept    = start && (state_q == ST_IDLE);
		case (state_q)
			ST_MUL1: cmd.mult1 = 1'b1;
			ST_CHK: begin
				if (sts.thr_zero) begin
					cmd.w_load = 1'b1;
					cmd.w_sel  = dfg_pkg::WSEL_MAX;
				end else begin
					cmd.div_go = 1'b1;
				end
			end
			ST_DIV1: begin
				cmd.t_load = sts.div_done;
				if (sts.div_done && sts.p_over) begin
					cmd.w_load = 1'b1;
					cmd.w_sel  = dfg_pkg::WSEL_ZERO;
				end
			end
			ST_MUL2: cmd.mult2 = 1'b1;
			ST_RCP:  cmd.rcp = 1'b1;
			ST_QEST: cmd.qest = 1'b1;
			ST_FIX: begin
				cmd.w_load = 1'b1;
				cmd.w_sel  = dfg_pkg::WSEL_DIV;
			end
			ST_SRCH: cmd.srch_step = 1'b1;
			default: ;
		endcase
	end

endmodule

### rtl/dvfs_frequency_governor.sv
// ----------------------------------------------------------------------------
// dvfs_frequency_governor
// Per-epoch cluster frequency governor with tracked-application table.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// command   start / busy           mode, current_freq_khz, app_id, throughput,
//                                  required_throughput, sleep_us, table_index,
//                                  table_value_khz
// result    done (one cycle)       target_freq_khz, apply_change, new_app_seen,
//                                  ended_app_seen, table_full_error
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// start, epoch end and table write complete at the transfer; the epoch end result
// shows on done the cycle after the transfer. A report keeps busy high through
// the setup states (multiply, check), the one-bit-per-cycle divider, the sleep
// factor and its reciprocal division, then the table search. Zero throughput
// skips from setup to the search, sleep beyond the period from the divider. Reset
// clears the control state; config is ready only when idle with no command offered.
// ----------------------------------------------------------------------------
module dvfs_frequency_governor #(
	parameter int MAX_APPS     = dfg_pkg::MAX_APPS_DEF,
	parameter int FREQ_ENTRIES = dfg_pkg::FREQ_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [dfg_pkg::FREQ_W-1:0]    current_freq_khz,
	input  logic [dfg_pkg::FREQ_W-1:0]    app_id,
	input  logic [dfg_pkg::THR_W-1:0]     throughput,
	input  logic [dfg_pkg::THR_W-1:0]     required_throughput,
	input  logic [dfg_pkg::SLEEP_W-1:0]   sleep_us,
	input  logic [3:0]                    table_index,
	input  logic [dfg_pkg::FREQ_W-1:0]    table_value_khz,
	output logic                          done,
	output logic [dfg_pkg::FREQ_W-1:0]    target_freq_khz,
	output logic                          apply_change,
	output logic                          new_app_seen,
	output logic                          ended_app_seen,
	output logic                          table_full_error,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dfg_pkg::FREQ_W-1:0]    cfg_data
);

	dfg_pkg::cmd_t cmd;
	dfg_pkg::sts_t sts;

	// settings change only with no command in flight or offered
	assign cfg_ready = !busy && !start;

	dfg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dfg_dp #(
		.MAX_APPS     (MAX_APPS),
		.FREQ_ENTRIES (FREQ_ENTRIES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.mode                (mode),
		.current_freq_khz    (current_freq_khz),
		.app_id              (app_id),
		.throughput          (throughput),
		.required_throughput (required_throughput),
		.sleep_us            (sleep_us),
		.table_index         (table_index),
		.table_value_khz     (table_value_khz),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.done                (done),
		.target_freq_khz     (target_freq_khz),
		.apply_change        (apply_change),
		.new_app_seen        (new_app_seen),
		.ended_app_seen      (ended_app_seen),
		.table_full_error    (table_full_error)
	);

endmodule

### rtl/dfg_checker.sv
// ----------------------------------------------------------------------------
// dfg_checker
// Port-level checks of the governor, bound to the top level.
// ----------------------------------------------------------------------------
module dfg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       done,
	input logic       apply_change,
	input logic       new_app_seen
);

	// a result only follows an epoch end transfer
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && mode == dfg_pkg::MODE_END))
		else $error("result without epoch end");

	// busy only rises after a report transfer
	a_busy_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && mode == dfg_pkg::MODE_REPORT))
		else $error("busy without report");

	// no change is requested in an epoch with a new application
	a_no_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_app_seen) |-> !apply_change)
		else $error("change requested with new application");

endmodule

bind dvfs_frequency_governor dfg_checker u_dfg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.done         (done),
	.apply_change (apply_change),
	.new_app_seen (new_app_seen)
);
